>>> src/sis_pkg.sv
// Package: widths and pipeline item type for the segment intersection setback block.
`timescale 1ns / 1ps
package sis_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int CW   = COORD_WIDTH;
    localparam int AW   = CW + 1;
    localparam int PW   = 2 * CW;
    localparam int CWID = 2 * CW + 1;
    localparam int MW   = AW + CW;
    localparam int EW   = 2 * AW;
    localparam int SW   = 2 * CW + 3;
    localparam int DW   = 2 * CW + 3;
    localparam int NPW  = AW + CWID;
    localparam int NW   = NPW + 1;
    localparam int QW   = CW + 2;
    localparam int RW   = DW + QW;
    localparam int QSW  = AW + QW + 1;
    localparam int Q2W  = QSW + 2;

    typedef struct packed {
        logic signed [CW-1:0]   x1, y1, x2, y2;
        logic signed [CW-1:0]   px1, py1, px2, py2;
        logic                   si_neg, si_zero, right;
        logic signed [AW-1:0]   a1, b1, a2, b2;
        logic signed [PW-1:0]   p_x2y1, p_x1y2, p_px2py1, p_px1py2;
        logic signed [CWID-1:0] c1, c2;
        logic signed [MW-1:0]   ma1px1, mb1py1, ma1px2, mb1py2;
        logic signed [MW-1:0]   ma2x1, mb2y1, ma2x2, mb2y2;
        logic signed [EW-1:0]   ae, bd;
        logic signed [SW-1:0]   r1, r2, r3, r4;
        logic signed [DW-1:0]   den;
        logic signed [NPW-1:0]  nb1c2, nb2c1, na1c2, na2c1;
        logic                   hit, t1_neg, negx, negy;
        logic signed [NW-1:0]   numx, numy;
        logic [RW-1:0]          remx, remy;
        logic [DW-1:0]          dabs;
        logic [QW-1:0]          qx, qy;
        logic signed [QW:0]     nx, ny;
        logic signed [QSW-1:0]  sa, sb;
    } t_item;
endpackage

>>> src/segment_intersect_setback.sv
// Top level: pipelined segment intersection with one-unit setback toward the start.
// Throughput: one transaction per cycle; busy is never raised, the receiver cannot stall.
// The 18 stages of the restoring divider set the depth; every stage takes one step.
// Reset: synchronous, active low, clears the valid bits only; payload is not reset.
`timescale 1ns / 1ps
module segment_intersect_setback import sis_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CW-1:0] i_start_x,
    input  logic signed [CW-1:0] i_start_y,
    input  logic signed [CW-1:0] i_end_x,
    input  logic signed [CW-1:0] i_end_y,
    input  logic signed [CW-1:0] i_wall_ax,
    input  logic signed [CW-1:0] i_wall_ay,
    input  logic signed [CW-1:0] i_wall_bx,
    input  logic signed [CW-1:0] i_wall_by,
    input  logic signed [1:0]    i_inside_side,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic signed [CW-1:0] o_new_end_x,
    output logic signed [CW-1:0] o_new_end_y
);
    localparam int NSTG = 5 + QW + 3;

    t_item r_s1, r_s2, r_s3, r_s4, r_s5, r_p1, r_p2, r_p3;
    t_item n_s1, n_s2, n_s3, n_s4, n_s5, n_p1, n_p2, n_p3;
    t_item r_div [QW];
    t_item n_div [QW];
    logic [NSTG-1:0] r_vld;
    logic                 r_valid, r_hit;
    logic signed [CW-1:0] r_nx, r_ny;
    logic                 n_hit;
    logic signed [CW-1:0] n_nx, n_ny;

    assign busy = 1'b0;

    function automatic logic straddle(input logic signed [SW-1:0] u, input logic signed [SW-1:0] v);
        logic su, sv;
        su = (u != '0);
        sv = (v != '0);
        return !su || !sv || (u[SW-1] != v[SW-1]);
    endfunction

    always_comb begin
        logic swap;
        logic signed [CW-1:0] ax, ay, bx, by;
        swap = (i_wall_ay < i_wall_by) || ((i_wall_ay == i_wall_by) && (i_wall_ax > i_wall_bx));
        ax = swap ? i_wall_bx : i_wall_ax;
        ay = swap ? i_wall_by : i_wall_ay;
        bx = swap ? i_wall_ax : i_wall_bx;
        by = swap ? i_wall_ay : i_wall_by;
        n_s1 = '0;
        n_s1.x1 = i_start_x;
        n_s1.y1 = i_start_y;
        n_s1.x2 = i_end_x;
        n_s1.y2 = i_end_y;
        n_s1.px1 = ax;
        n_s1.py1 = ay;
        n_s1.px2 = bx;
        n_s1.py2 = by;
        n_s1.si_neg = i_inside_side[1];
        n_s1.si_zero = (i_inside_side == '0);
        n_s1.right = (ax < bx);
        n_s1.a1 = AW'($signed(i_end_y) - $signed(i_start_y));
        n_s1.b1 = AW'($signed(i_start_x) - $signed(i_end_x));
        n_s1.a2 = AW'($signed(by) - $signed(ay));
        n_s1.b2 = AW'($signed(ax) - $signed(bx));
        n_s1.p_x2y1 = PW'($signed(i_end_x) * $signed(i_start_y));
        n_s1.p_x1y2 = PW'($signed(i_start_x) * $signed(i_end_y));
        n_s1.p_px2py1 = PW'($signed(bx) * $signed(ay));
        n_s1.p_px1py2 = PW'($signed(ax) * $signed(by));
    end

    always_comb begin
        n_s2 = r_s1;
        n_s2.c1 = CWID'($signed(r_s1.p_x2y1) - $signed(r_s1.p_x1y2));
        n_s2.c2 = CWID'($signed(r_s1.p_px2py1) - $signed(r_s1.p_px1py2));
        n_s2.ma1px1 = MW'($signed(r_s1.a1) * $signed(r_s1.px1));
        n_s2.mb1py1 = MW'($signed(r_s1.b1) * $signed(r_s1.py1));
        n_s2.ma1px2 = MW'($signed(r_s1.a1) * $signed(r_s1.px2));
        n_s2.mb1py2 = MW'($signed(r_s1.b1) * $signed(r_s1.py2));
        n_s2.ma2x1 = MW'($signed(r_s1.a2) * $signed(r_s1.x1));
        n_s2.mb2y1 = MW'($signed(r_s1.b2) * $signed(r_s1.y1));
        n_s2.ma2x2 = MW'($signed(r_s1.a2) * $signed(r_s1.x2));
        n_s2.mb2y2 = MW'($signed(r_s1.b2) * $signed(r_s1.y2));
        n_s2.ae = EW'($signed(r_s1.a1) * $signed(r_s1.b2));
        n_s2.bd = EW'($signed(r_s1.b1) * $signed(r_s1.a2));
    end

    always_comb begin
        n_s3 = r_s2;
        n_s3.r1 = SW'($signed(r_s2.ma1px1) + $signed(r_s2.mb1py1) + $signed(r_s2.c1));
        n_s3.r2 = SW'($signed(r_s2.ma1px2) + $signed(r_s2.mb1py2) + $signed(r_s2.c1));
        n_s3.r3 = SW'($signed(r_s2.ma2x1) + $signed(r_s2.mb2y1) + $signed(r_s2.c2));
        n_s3.r4 = SW'($signed(r_s2.ma2x2) + $signed(r_s2.mb2y2) + $signed(r_s2.c2));
        n_s3.den = DW'($signed(r_s2.ae) - $signed(r_s2.bd));
        n_s3.nb1c2 = NPW'($signed(r_s2.b1) * $signed(r_s2.c2));
        n_s3.nb2c1 = NPW'($signed(r_s2.b2) * $signed(r_s2.c1));
        n_s3.na1c2 = NPW'($signed(r_s2.a1) * $signed(r_s2.c2));
        n_s3.na2c1 = NPW'($signed(r_s2.a2) * $signed(r_s2.c1));
    end

    always_comb begin
        logic s2_zero, s2_neg, ok;
        s2_zero = (r_s3.r4 == '0);
        s2_neg = r_s3.r4[SW-1];
        ok = r_s3.si_zero || s2_zero ||
             (r_s3.right ? (s2_neg == r_s3.si_neg) : (s2_neg != r_s3.si_neg));
        n_s4 = r_s3;
        n_s4.hit = straddle(r_s3.r1, r_s3.r2) && straddle(r_s3.r3, r_s3.r4) && ok &&
                   (r_s3.den != '0);
        n_s4.t1_neg = r_s3.r3[SW-1];
        n_s4.numx = NW'($signed(r_s3.nb1c2) - $signed(r_s3.nb2c1));
        n_s4.numy = NW'($signed(r_s3.na1c2) - $signed(r_s3.na2c1));
    end

    always_comb begin
        logic signed [RW-1:0] ex, ey, ed;
        ex = RW'(r_s4.numx);
        ey = RW'(r_s4.numy);
        ed = RW'(r_s4.den);
        n_s5 = r_s4;
        n_s5.remx = ex[RW-1] ? $unsigned(-ex) : $unsigned(ex);
        n_s5.remy = ey[RW-1] ? $unsigned(-ey) : $unsigned(ey);
        n_s5.dabs = ed[RW-1] ? DW'($unsigned(-ed)) : DW'($unsigned(ed));
        n_s5.negx = r_s4.numx[NW-1] ^ r_s4.den[DW-1];
        n_s5.negy = r_s4.numy[NW-1] ^ ~r_s4.den[DW-1];
        n_s5.qx = '0;
        n_s5.qy = '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_comb begin
            t_item src;
            logic [RW-1:0] dsh;
            src = (k == 0) ? r_s5 : r_div[(k == 0) ? 0 : k-1];
            dsh = RW'(src.dabs) << (QW-1-k);
            n_div[k] = src;
            if (src.remx >= dsh) begin
                n_div[k].remx = src.remx - dsh;
                n_div[k].qx[QW-1-k] = 1'b1;
            end
            if (src.remy >= dsh) begin
                n_div[k].remy = src.remy - dsh;
                n_div[k].qy[QW-1-k] = 1'b1;
            end
        end
    end

    always_comb begin
        logic signed [QW:0] ux, uy;
        ux = $signed({1'b0, r_div[QW-1].qx});
        uy = $signed({1'b0, r_div[QW-1].qy});
        n_p1 = r_div[QW-1];
        n_p1.nx = r_div[QW-1].negx ? -ux : ux;
        n_p1.ny = r_div[QW-1].negy ? -uy : uy;
    end

    always_comb begin
        logic signed [QW:0] sx1, sy1;
        sx1 = (QW+1)'(r_p1.x1);
        sy1 = (QW+1)'(r_p1.y1);
        n_p2 = r_p1;
        if (r_p1.nx > sx1) begin
            n_p2.nx = r_p1.nx - (QW+1)'(1);
        end else if (r_p1.nx < sx1) begin
            n_p2.nx = r_p1.nx + (QW+1)'(1);
        end
        if (r_p1.ny > sy1) begin
            n_p2.ny = r_p1.ny - (QW+1)'(1);
        end else if (r_p1.ny < sy1) begin
            n_p2.ny = r_p1.ny + (QW+1)'(1);
        end
    end

    always_comb begin
        n_p3 = r_p2;
        n_p3.sa = QSW'($signed(r_p2.a2) * $signed(r_p2.nx));
        n_p3.sb = QSW'($signed(r_p2.b2) * $signed(r_p2.ny));
    end

    always_comb begin
        logic signed [Q2W-1:0] q2;
        logic clamp;
        q2 = Q2W'($signed(r_p3.sa) + $signed(r_p3.sb) + $signed(r_p3.c2));
        clamp = !r_p3.si_zero && (q2 != '0) && (r_p3.t1_neg != q2[Q2W-1]);
        n_hit = r_p3.hit;
        if (!r_p3.hit) begin
            n_nx = r_p3.x2;
            n_ny = r_p3.y2;
        end else if (clamp) begin
            n_nx = r_p3.x1;
            n_ny = r_p3.y1;
        end else begin
            n_nx = r_p3.nx[CW-1:0];
            n_ny = r_p3.ny[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
        r_s3 <= n_s3;
        r_s4 <= n_s4;
        r_s5 <= n_s5;
        r_div <= n_div;
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
        r_hit <= n_hit;
        r_nx <= n_nx;
        r_ny <= n_ny;
        if (!i_rst_n) begin
            r_vld <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], start};
            r_valid <= r_vld[NSTG-1];
        end
    end

    assign o_valid = r_valid;
    assign o_hit = r_hit;
    assign o_new_end_x = r_nx;
    assign o_new_end_y = r_ny;
endmodule
